[sv/replay_window_check_assert.svh]
// ----------------------------------------------------------------------------
// replay_window_check assertion macros
// immediate-cycle and next-cycle implication checks, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef REPLAY_WINDOW_CHECK_ASSERT_SVH
`define REPLAY_WINDOW_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define RWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("replay window check assertion failed");
`define RWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("replay window check assertion failed");
`else
`define RWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/rwc_pkg.sv]
// ----------------------------------------------------------------------------
// rwc_pkg
// shared types, field widths and verdict codes of the replay window check
// ----------------------------------------------------------------------------
package rwc_pkg;

	localparam int SLOT_W      = 6;
	localparam int SEQ_W       = 32;
	localparam int VERDICT_W   = 2;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = 6;
	localparam int QUEUE_DEPTH = 2;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_OLD    = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_DUP    = 2'd2;

	// classified item moving from front to back
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [SEQ_W-1:0]  seq;
		logic              bad;
	} rwc_item_t;

	// queue handshake and fill status
	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} rwc_queue_stat_t;

	// index of the lowest set bit of a bitmap word, zero if none
	function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

endpackage

[sv/rwc_front.sv]
// ----------------------------------------------------------------------------
// rwc_front
// takes input items, flags slots beyond the stream table, feeds the queue
// ----------------------------------------------------------------------------
module rwc_front #(
	parameter int STREAMS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rwc_pkg::SLOT_W-1:0]    stream_slot,
	input  logic [rwc_pkg::SEQ_W-1:0]     sequence_number,
	output logic                          push,
	output rwc_pkg::rwc_item_t            push_item,
	input  logic                          full
);
	import rwc_pkg::*;

	logic      valid_s1;
	rwc_item_t item_s1;

	// hand the staged item to the queue when it has room
	assign push      = valid_s1 && !full;
	assign push_item = item_s1;
	assign in_ready  = !valid_s1 || push;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload with slot range class
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.slot <= stream_slot;
			item_s1.seq  <= sequence_number;
			item_s1.bad  <= (32'(stream_slot) >= STREAMS);
		end
	end

endmodule

[sv/rwc_queue.sv]
// ----------------------------------------------------------------------------
// rwc_queue
// short item queue between the front and the back
// ----------------------------------------------------------------------------
module rwc_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rwc_pkg::rwc_item_t         push_item,
	input  logic                       pop,
	output rwc_pkg::rwc_item_t         head,
	output rwc_pkg::rwc_queue_stat_t   stat
);
	import rwc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	rwc_item_t        entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.push  = push;
	assign stat.pop   = pop;
	assign stat.full  = (fill_q == NW'(QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[sv/rwc_back.sv]
// ----------------------------------------------------------------------------
// rwc_back
// per-stream lookup, verdict, bitmap update and window slide, one word a cycle
// ----------------------------------------------------------------------------
module rwc_back #(
	parameter int STREAMS = 64,
	parameter int WINDOW  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  rwc_pkg::rwc_item_t            head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rwc_pkg::VERDICT_W-1:0] verdict
);
	import rwc_pkg::*;

	localparam int WORDS = (WINDOW + WORD_W) / WORD_W;
	localparam int WI    = $clog2(WORDS);
	localparam int CW    = $clog2(WORDS + 2);
	localparam int SRCW  = $clog2(2 * WORDS + 2);
	localparam int AW    = $clog2(STREAMS * WORDS);
	localparam int SW    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int CNW   = $clog2(WINDOW + 2);
	localparam int OW    = $clog2(WINDOW + 1);
	localparam int LW    = WI + BIT_W;
	localparam int WFULL = WINDOW / WORD_W;
	localparam int WREM  = WINDOW % WORD_W;
	localparam int IW    = SEQ_W + CNW;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_FILL   = 3'd3;
	localparam logic [2:0] ST_SHIFT  = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	// control registers
	logic [2:0]            state_q, state_d;
	logic                  out_valid_q, out_valid_d;
	logic [STREAMS-1:0]    used_q, used_d;

	// datapath registers
	rwc_item_t             item_q, item_d;
	logic [AW-1:0]         bit_base_q, bit_base_d;
	logic [SEQ_W-1:0]      base_q, base_d;
	logic [CNW-1:0]        count_q, count_d;
	logic [OW-1:0]         off_q, off_d;
	logic [WI-1:0]         ws_q, ws_d;
	logic [BIT_W-1:0]      bs_q, bs_d;
	logic                  first_q, first_d;
	logic                  fill_ones_q, fill_ones_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic                  rvalid_q, rvalid_d;
	logic [WORD_W-1:0]     prev_q, prev_d;
	logic                  low_found_q, low_found_d;
	logic [LW-1:0]         low_q, low_d;
	logic [VERDICT_W-1:0]  verdict_q, verdict_d;
	logic                  upd_q, upd_d;
	logic [VERDICT_W-1:0]  out_verdict_q, out_verdict_d;

	// memories
	logic [WORD_W-1:0]     bm_mem [STREAMS*WORDS];
	logic [WORD_W-1:0]     bm_rd_q;
	logic [IW-1:0]         info_mem [STREAMS];
	logic [IW-1:0]         info_rd_q;

	// memory controls
	logic                  bm_re, bm_we, info_re, info_we;
	logic [WI-1:0]         bm_rword, bm_wword;
	logic [WORD_W-1:0]     bm_wdata;
	logic [AW-1:0]         bm_raddr, bm_waddr;

	// working values
	logic [SW-1:0]         head_idx, sidx;
	logic [WORD_W-1:0]     cur, shifted, mark, sh_word, fill_word;
	logic [SRCW-1:0]       src;
	logic [CW-1:0]         wr_idx;
	logic [LW-1:0]         cand, low_final;
	logic [SEQ_W-1:0]      info_base, off, sh;
	logic [CNW-1:0]        info_cnt;

	assign head_idx  = SW'(head.slot);
	assign sidx      = SW'(item_q.slot);
	assign bm_raddr  = bit_base_q + AW'(bm_rword);
	assign bm_waddr  = bit_base_q + AW'(bm_wword);
	assign out_valid = out_valid_q;
	assign verdict   = out_verdict_q;

	// next state and memory controls
	always_comb begin
		state_d       = state_q;
		out_valid_d   = out_valid_q && !out_ready;
		used_d        = used_q;
		item_d        = item_q;
		bit_base_d    = bit_base_q;
		base_d        = base_q;
		count_d       = count_q;
		off_d         = off_q;
		ws_d          = ws_q;
		bs_d          = bs_q;
		first_d       = first_q;
		fill_ones_d   = fill_ones_q;
		cnt_d         = cnt_q;
		prev_d        = prev_q;
		low_found_d   = low_found_q;
		low_d         = low_q;
		verdict_d     = verdict_q;
		upd_d         = upd_q;
		out_verdict_d = out_verdict_q;
		bm_re         = 1'b0;
		bm_we         = 1'b0;
		bm_rword      = '0;
		bm_wword      = '0;
		bm_wdata      = '0;
		info_re       = 1'b0;
		info_we       = 1'b0;
		pop           = 1'b0;

		// slide datapath: funnel shift of two adjacent words
		cur       = rvalid_q ? bm_rd_q : '0;
		src       = SRCW'(ws_q) + SRCW'(cnt_q);
		wr_idx    = cnt_q - CW'(2);
		shifted   = 64'({cur, prev_q} >> bs_q);
		mark      = (first_q && wr_idx == CW'(WFULL)) ? (64'(1) << WREM) : '0;
		sh_word   = shifted | mark;
		cand      = {WI'(wr_idx), lowest_bit(sh_word)};
		low_final = low_found_q ? low_q : cand;

		// fill pattern: fresh window or a full window less its oldest entry
		if (fill_ones_q) begin
			if (cnt_q < CW'(WFULL)) begin
				fill_word = '1;
			end else if (cnt_q == CW'(WFULL)) begin
				fill_word = (64'(1) << WREM) - 64'(1);
			end else begin
				fill_word = '0;
			end
		end else begin
			fill_word = (cnt_q == '0) ? 64'(1) : '0;
		end

		info_base = info_rd_q[IW-1:CNW];
		info_cnt  = info_rd_q[CNW-1:0];
		off       = item_q.seq - info_base;
		sh        = off - SEQ_W'(WINDOW);

		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop        = 1'b1;
					item_d     = head;
					bit_base_d = AW'(head_idx) * AW'(WORDS);
					if (head.bad) begin
						verdict_d = VERDICT_OLD;
						upd_d     = 1'b0;
						state_d   = ST_RESULT;
					end else begin
						info_re = 1'b1;
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				if (!used_q[sidx]) begin
					used_d[sidx] = 1'b1;
					base_d       = item_q.seq;
					count_d      = CNW'(1);
					fill_ones_d  = 1'b0;
					cnt_d        = '0;
					state_d      = ST_FILL;
				end else if (item_q.seq < info_base) begin
					verdict_d = VERDICT_OLD;
					upd_d     = 1'b0;
					state_d   = ST_RESULT;
				end else if (off <= SEQ_W'(WINDOW)) begin
					bm_re    = 1'b1;
					bm_rword = WI'(off >> BIT_W);
					off_d    = OW'(off);
					base_d   = info_base;
					count_d  = info_cnt;
					state_d  = ST_CHECK;
				end else if (sh > SEQ_W'(WINDOW)) begin
					// every retained number falls out: restart at this one
					base_d      = item_q.seq;
					count_d     = CNW'(1);
					fill_ones_d = 1'b0;
					cnt_d       = '0;
					state_d     = ST_FILL;
				end else begin
					ws_d        = WI'(sh >> BIT_W);
					bs_d        = sh[BIT_W-1:0];
					first_d     = 1'b1;
					base_d      = item_q.seq - SEQ_W'(WINDOW);
					count_d     = '0;
					cnt_d       = '0;
					low_found_d = 1'b0;
					state_d     = ST_SHIFT;
				end
			end
			ST_CHECK: begin
				if (bm_rd_q[off_q[BIT_W-1:0]]) begin
					verdict_d = VERDICT_DUP;
					upd_d     = 1'b0;
					state_d   = ST_RESULT;
				end else if (count_q == CNW'(WINDOW)) begin
					// window full: oldest drops, base moves up by one
					fill_ones_d = 1'b1;
					cnt_d       = '0;
					base_d      = base_q + SEQ_W'(1);
					state_d     = ST_FILL;
				end else begin
					bm_we     = 1'b1;
					bm_wword  = WI'(off_q >> BIT_W);
					bm_wdata  = bm_rd_q | (64'(1) << off_q[BIT_W-1:0]);
					count_d   = count_q + CNW'(1);
					verdict_d = VERDICT_ACCEPT;
					upd_d     = 1'b1;
					state_d   = ST_RESULT;
				end
			end
			ST_FILL: begin
				bm_we    = 1'b1;
				bm_wword = WI'(cnt_q);
				bm_wdata = fill_word;
				if (cnt_q == CW'(WORDS - 1)) begin
					verdict_d = VERDICT_ACCEPT;
					upd_d     = 1'b1;
					state_d   = ST_RESULT;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			ST_SHIFT: begin
				bm_re    = (cnt_q < CW'(WORDS)) && (src < SRCW'(WORDS));
				bm_rword = WI'(src);
				prev_d   = cur;
				if (cnt_q >= CW'(2)) begin
					bm_we    = 1'b1;
					bm_wword = WI'(wr_idx);
					bm_wdata = sh_word;
					if (first_q) begin
						count_d = count_q + CNW'($countones(sh_word));
						if (!low_found_q && sh_word != '0) begin
							low_found_d = 1'b1;
							low_d       = cand;
						end
					end
				end
				if (cnt_q == CW'(WORDS + 1)) begin
					if (first_q && low_final != '0) begin
						// second pass drops the gap below the lowest survivor
						ws_d    = low_final[LW-1:BIT_W];
						bs_d    = low_final[BIT_W-1:0];
						first_d = 1'b0;
						cnt_d   = '0;
						base_d  = base_q + SEQ_W'(low_final);
					end else begin
						verdict_d = VERDICT_ACCEPT;
						upd_d     = 1'b1;
						state_d   = ST_RESULT;
					end
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d   = 1'b1;
					out_verdict_d = verdict_q;
					info_we       = upd_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rvalid_d = bm_re;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			used_q      <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			used_q      <= used_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		item_q        <= item_d;
		bit_base_q    <= bit_base_d;
		base_q        <= base_d;
		count_q       <= count_d;
		off_q         <= off_d;
		ws_q          <= ws_d;
		bs_q          <= bs_d;
		first_q       <= first_d;
		fill_ones_q   <= fill_ones_d;
		cnt_q         <= cnt_d;
		rvalid_q      <= rvalid_d;
		prev_q        <= prev_d;
		low_found_q   <= low_found_d;
		low_q         <= low_d;
		verdict_q     <= verdict_d;
		upd_q         <= upd_d;
		out_verdict_q <= out_verdict_d;
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rd_q <= bm_mem[bm_raddr];
		end
	end

	// per-stream base and count memory
	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[sidx] <= {base_q, count_q};
		end
		if (info_re) begin
			info_rd_q <= info_mem[head_idx];
		end
	end

endmodule

[sv/replay_window_check.sv]
// ----------------------------------------------------------------------------
// replay_window_check
// anti-replay filter: per-stream sliding window of accepted sequence numbers
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  input   | in_valid / in_ready  | stream_slot, sequence_number
//  output  | out_valid / out_ready| verdict
//
//  WORDS = WINDOW/64 + 1 bitmap words per stream, one word a cycle.
//  Back paths per item: bad slot, too old, duplicate or in-window accept,
//  fresh stream or jump past the window (bitmap fill), full window (fill),
//  and the window slide (up to two shift passes).
//  Reset clears the stream-used bits at once; there is no clearing pass.
//  The output register and the item queue let input and output stall apart.
`include "replay_window_check_assert.svh"

module replay_window_check #(
	parameter int STREAMS = 64,
	parameter int WINDOW  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rwc_pkg::SLOT_W-1:0]    stream_slot,
	input  logic [rwc_pkg::SEQ_W-1:0]     sequence_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rwc_pkg::VERDICT_W-1:0] verdict
);
	import rwc_pkg::*;

	logic            push;
	logic            pop;
	rwc_item_t       push_item;
	rwc_item_t       head;
	rwc_queue_stat_t q_stat;

	// front: accept and classify
	rwc_front #(
		.STREAMS (STREAMS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.stream_slot     (stream_slot),
		.sequence_number (sequence_number),
		.push            (push),
		.push_item       (push_item),
		.full            (q_stat.full)
	);

	// item queue
	rwc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// back: window lookup and update
	rwc_back #(
		.STREAMS (STREAMS),
		.WINDOW  (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_stat.empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

	// queue never written full nor read empty; a push without a pop leaves it non-empty
	`RWC_ASSERT_NOW(a_push_room, clk, arst_n, q_stat.push, !q_stat.full)
	`RWC_ASSERT_NOW(a_pop_data, clk, arst_n, q_stat.pop, !q_stat.empty)
	`RWC_ASSERT_NEXT(a_push_lands, clk, arst_n, q_stat.push && !q_stat.pop, !q_stat.empty)

endmodule
